FILE: rtl/pud_pkg.sv
// Shared types, character codes and the hex digit function of the URL percent decoder.
package pud_pkg;

  // Character codes used by the decoder.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // Position inside an escape sequence.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  // Number of decoded characters produced by one input transfer.
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_ONE  = 2'd1,
    EMIT_TWO  = 2'd2
  } emit_t;

  // Decoded characters handed from the decoder to the output queue.
  typedef struct packed {
    emit_t      emit;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
  } dec_out_t;

  // Value of a hex digit; anything that is not a hex digit gives zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      v = c - CH_UP_A + HEX_TEN;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      v = c - CH_LO_A + HEX_TEN;
    end
    return v[3:0];
  endfunction

  // A plus sign stands for a space; everything else passes unchanged.
  function automatic logic [7:0] plain_char(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

FILE: rtl/url_percent_decoder_top.sv
// Top level of the streaming URL percent decoder.
// The decoder takes one encoded character per clock while in_stall is low and delivers the
// decoded characters in order through a four-entry result queue: a plus sign becomes a space,
// a percent sign and two following characters become one byte, and a percent sign near the
// end of a string passes through. A character is registered on its input transfer and decoded
// once the result queue has room, and its results are registered in the queue. in_stall rises
// only while a character is held and the result queue has fewer than two free slots, which the
// output side sets by its stall.
module url_percent_decoder_top
  import pud_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       item_valid_r, item_valid_nxt;
  logic [7:0] item_byte_r;
  logic       item_last_r;
  logic       room;
  logic       take;
  dec_out_t   dec;

  assign in_stall = item_valid_r && !room;
  assign take     = in_valid && !in_stall;

  // Input register; it empties when its character is decoded.
  always_comb begin
    item_valid_nxt = item_valid_r && !room;
    if (take) begin
      item_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_byte_r <= in_byte;
      item_last_r <= in_last;
    end
  end

  pud_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid_r),
    .item_byte  (item_byte_r),
    .item_last  (item_last_r),
    .advance    (room),
    .dec        (dec)
  );

  pud_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: rtl/pud_decode.sv
// Escape state machine that turns one registered character into zero, one or two decoded ones.
module pud_decode
  import pud_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  input  logic       advance,
  output dec_out_t   dec
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] high_r, high_nxt;
  logic [3:0] nib;

  assign nib = nibble_of(item_byte);

  // State register; it moves only when the held character is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      high_r  <= 4'd0;
    end else if (item_valid && advance) begin
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
    end
  end

  // Next state and decoded characters for the held character.
  always_comb begin
    phase_nxt = PH_IDLE;
    high_nxt  = high_r;
    dec.emit  = EMIT_NONE;
    dec.byte0 = plain_char(item_byte);
    dec.last0 = item_last;
    dec.byte1 = plain_char(item_byte);
    dec.last1 = item_last;
    unique case (phase_r)
      PH_FIRST: begin
        if (item_last) begin
          // A percent sign followed by only one character passes through.
          dec.emit  = EMIT_TWO;
          dec.byte0 = CH_PERCENT;
          dec.last0 = 1'b0;
          high_nxt  = 4'd0;
        end else begin
          high_nxt  = nib;
          phase_nxt = PH_SECOND;
        end
      end
      PH_SECOND: begin
        dec.emit  = EMIT_ONE;
        dec.byte0 = {high_r, nib};
      end
      default: begin
        if (item_byte == CH_PERCENT && !item_last) begin
          phase_nxt = PH_FIRST;
        end else begin
          dec.emit = EMIT_ONE;
        end
      end
    endcase
    // Nothing reaches the queue unless the held character is consumed in this cycle.
    if (!(item_valid && advance)) begin
      dec.emit = EMIT_NONE;
    end
  end

endmodule

FILE: rtl/pud_out_fifo.sv
// Four-entry result queue; up to two characters in per cycle, one out when not stalled.
module pud_out_fifo
  import pud_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dec_out_t   dec,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int DEPTH = 4;

  logic [7:0] byte_r [DEPTH];
  logic       last_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] wr_ptr_p1;
  logic       pop;
  logic [2:0] push_n;

  // Room for the largest burst of one transfer, regardless of the pop.
  assign room      = (count_r <= 3'(DEPTH - 2));
  assign out_valid = (count_r != 3'd0);
  assign out_byte  = byte_r[rd_ptr_r];
  assign out_last  = last_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign push_n    = {1'b0, dec.emit};
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n[1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    count_nxt  = count_r + push_n - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; the second character goes to the slot after the first.
  always_ff @(posedge clk) begin
    if (dec.emit != EMIT_NONE) begin
      byte_r[wr_ptr_r] <= dec.byte0;
      last_r[wr_ptr_r] <= dec.last0;
    end
    if (dec.emit == EMIT_TWO) begin
      byte_r[wr_ptr_p1] <= dec.byte1;
      last_r[wr_ptr_p1] <= dec.last1;
    end
  end

endmodule

FILE: rtl/pud_checker.sv
// Port-level checker of the URL percent decoder and its bind to the top level.
module pud_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled input transfer stays offered with its payload unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("input withdrawn or changed while stalled");

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_last))
    else $error("result payload changed while stalled");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Reset empties the input register, so the first transfer is never stalled.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind url_percent_decoder_top pud_checker u_pud_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_byte   (in_byte),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

FILE: tb/url_percent_decoder_top_tb.sv
// Self-checking testbench for the streaming URL percent decoder top level.
`timescale 1ns / 100ps

module url_percent_decoder_top_tb;
  import pud_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_STRING_LEN = 12;

  // One decoded character as it leaves the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dec_char_t;

  // One row of the directed table; typed rows carry their own expected results.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    emit_t      n;
    logic [7:0] b0;
    logic       l0;
    logic [7:0] b1;
    logic       l1;
  } stim_row_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  // Predictor state and the queue of decoded characters still to arrive.
  phase_t     esc_phase = PH_IDLE;
  logic [3:0] hi_nib    = 4'd0;
  dec_char_t  decoded_q[$];
  dec_char_t  head_exp;

  int err_count     = 0;
  int idle_pct      = 0;
  int out_stall_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;

  // Directed strings: extremes, plus sign, escapes, and escapes cut short by the end.
  stim_row_t directed_rows [0:23] = '{
    '{CH_LO_A,    1'b0, 1'b1, EMIT_ONE,  CH_LO_A,    1'b0, 8'h00,    1'b0},
    '{CH_PLUS,    1'b0, 1'b1, EMIT_ONE,  CH_SPACE,   1'b0, 8'h00,    1'b0},
    '{8'h01,      1'b0, 1'b1, EMIT_ONE,  8'h01,      1'b0, 8'h00,    1'b0},
    '{8'hFF,      1'b1, 1'b1, EMIT_ONE,  8'hFF,      1'b1, 8'h00,    1'b0},
    '{CH_PERCENT, 1'b0, 1'b1, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_UP_F,    1'b0, 1'b1, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_LO_F,    1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_PERCENT, 1'b0, 1'b1, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_ZERO,    1'b0, 1'b1, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_ZERO,    1'b1, 1'b1, EMIT_ONE,  8'h00,      1'b1, 8'h00,    1'b0},
    '{CH_PERCENT, 1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_NINE,    1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_UP_A,    1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_PERCENT, 1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_PERCENT, 1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_PLUS,    1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_PERCENT, 1'b1, 1'b1, EMIT_ONE,  CH_PERCENT, 1'b1, 8'h00,    1'b0},
    '{CH_PERCENT, 1'b0, 1'b1, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_PLUS,    1'b1, 1'b1, EMIT_TWO,  CH_PERCENT, 1'b0, CH_SPACE,   1'b1},
    '{CH_PERCENT, 1'b0, 1'b1, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{CH_PERCENT, 1'b1, 1'b1, EMIT_TWO,  CH_PERCENT, 1'b0, CH_PERCENT, 1'b1},
    '{CH_PERCENT, 1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{8'h67,      1'b0, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0},
    '{8'h7A,      1'b1, 1'b0, EMIT_NONE, 8'h00,      1'b0, 8'h00,    1'b0}
  };

  url_percent_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Value of a hex digit character; anything else counts as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c[3:0];
    end
    if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
      return c[3:0] + 4'd9;
    end
    return 4'd0;
  endfunction

  // Advances the predictor by one character and returns the decoded characters it yields.
  function automatic emit_t decode_step(input logic [7:0] c, input logic fin,
                                        output dec_char_t r0, output dec_char_t r1);
    emit_t n;
    n  = EMIT_NONE;
    r0 = '0;
    r1 = '0;
    case (esc_phase)
      PH_FIRST: begin
        if (fin) begin
          // A percent sign with only one character left passes through.
          r0 = '{CH_PERCENT, 1'b0};
          r1 = '{(c == CH_PLUS) ? CH_SPACE : c, 1'b1};
          hi_nib = 4'd0;
          esc_phase = PH_IDLE;
          n = EMIT_TWO;
        end else begin
          hi_nib = hex_value(c);
          esc_phase = PH_SECOND;
        end
      end
      PH_SECOND: begin
        r0 = '{{hi_nib, hex_value(c)}, fin};
        esc_phase = PH_IDLE;
        n = EMIT_ONE;
      end
      default: begin
        esc_phase = PH_IDLE;
        if (c == CH_PERCENT && !fin) begin
          esc_phase = PH_FIRST;
        end else begin
          r0 = '{(c == CH_PLUS) ? CH_SPACE : c, fin};
          n = EMIT_ONE;
        end
      end
    endcase
    return n;
  endfunction

  // Queues the decoded characters that one input transfer should produce.
  function automatic void queue_decoded(input emit_t n, input dec_char_t r0,
                                        input dec_char_t r1);
    if (n != EMIT_NONE) begin
      decoded_q.push_back(r0);
    end
    if (n == EMIT_TWO) begin
      decoded_q.push_back(r1);
    end
  endfunction

  // Random hex digit in either case.
  function automatic logic [7:0] hex_digit_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) begin
      return CH_ZERO + 8'(k);
    end else if (k < 16) begin
      return CH_UP_A + 8'(k - 10);
    end
    return CH_LO_A + 8'(k - 16);
  endfunction

  // Offers one character, with a random gap first, and returns after its transfer.
  task automatic send_item(input logic [7:0] c, input logic fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    in_last  <= fin;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Drops valid and waits until every expected character has been taken.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sends one string mostly of well-formed escapes, with plus signs, random bytes and lone
  // percent signs. Cutting to length leaves escapes open at the end now and then.
  task automatic send_random_string();
    logic [7:0] chars[$];
    int         len;
    int         pick;
    emit_t      n;
    dec_char_t  r0;
    dec_char_t  r1;
    len = $urandom_range(1, MAX_STRING_LEN);
    while (chars.size() < len) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        chars.push_back(CH_PERCENT);
        chars.push_back(hex_digit_char());
        chars.push_back(hex_digit_char());
      end else if (pick == 4) begin
        chars.push_back(CH_PLUS);
      end else if (pick == 5) begin
        chars.push_back(CH_PERCENT);
      end else begin
        chars.push_back(8'($urandom_range(1, 255)));
      end
    end
    while (chars.size() > len) begin
      void'(chars.pop_back());
    end
    foreach (chars[i]) begin
      send_item(chars[i], i == len - 1);
      n = decode_step(chars[i], i == len - 1, r0, r1);
      queue_decoded(n, r0, r1);
    end
  endtask

  // Sends random strings until the item count of this stretch is reached.
  task automatic run_random(input int item_count, input int in_idle, input int out_idle);
    int start_count;
    start_count   = items_sent;
    idle_pct      = in_idle;
    out_stall_pct = out_idle;
    while (items_sent - start_count < item_count) begin
      send_random_string();
    end
  endtask

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // Compares every output transfer with the oldest expected character.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected transfer: out_byte %h out_last %b", out_byte, out_last);
        err_count++;
      end else begin
        head_exp = decoded_q.pop_front();
        if (out_byte !== head_exp.ch) begin
          $error("out_byte: expected %h, actual %h", head_exp.ch, out_byte);
          err_count++;
        end
        if (out_last !== head_exp.last) begin
          $error("out_last: expected %b, actual %b", head_exp.last, out_last);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    emit_t     n;
    dec_char_t r0;
    dec_char_t r1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed rows replace the predicted characters with their own.
    idle_pct      = 24;
    out_stall_pct = 86;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].ch, directed_rows[i].last);
      n = decode_step(directed_rows[i].ch, directed_rows[i].last, r0, r1);
      if (directed_rows[i].typed) begin
        n  = directed_rows[i].n;
        r0 = '{directed_rows[i].b0, directed_rows[i].l0};
        r1 = '{directed_rows[i].b1, directed_rows[i].l1};
      end
      queue_decoded(n, r0, r1);
    end

    // Slow receiver first.
    run_random(600, 24, 86);

    // Long receiver hold-off while the sender keeps offering, then a full drain.
    hold_req++;
    run_random(60, 0, 0);
    pause_until_drained();

    // Slow sender, then full rate.
    run_random(600, 86, 24);
    run_random(600, 0, 0);

    // Let the last characters out and watch for stray transfers.
    out_stall_pct = 0;
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
